// ----- design/mips_rtype_execute_unit_assert.svh -----
// Assertion macros for the R-type execute unit.
`ifndef MIPS_RTYPE_EXECUTE_UNIT_ASSERT_SVH
`define MIPS_RTYPE_EXECUTE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define MRX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MRX_ASSERT_SAME(lbl, ante, cons, msg) \
    `MRX_ASSERT(lbl, (ante) |-> (cons), msg)
`define MRX_ASSERT_NEXT(lbl, ante, cons, msg) \
    `MRX_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define MRX_ASSERT(lbl, prop, msg)
`define MRX_ASSERT_SAME(lbl, ante, cons, msg)
`define MRX_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/mrx_pkg.sv -----
// Shared types and constants for the R-type execute unit.
package mrx_pkg;

    localparam int unsigned WORD_W = 32;
    localparam logic [WORD_W-1:0] LINK_OFFSET = 32'd8;

    typedef enum logic [4:0] {
        ACT_ADD   = 5'd0,
        ACT_ADDU  = 5'd1,
        ACT_AND   = 5'd2,
        ACT_DIV   = 5'd3,
        ACT_DIVU  = 5'd4,
        ACT_JR    = 5'd5,
        ACT_JALR  = 5'd6,
        ACT_MFHI  = 5'd7,
        ACT_MFLO  = 5'd8,
        ACT_MTHI  = 5'd9,
        ACT_MTLO  = 5'd10,
        ACT_MULT  = 5'd11,
        ACT_MULTU = 5'd12,
        ACT_OR    = 5'd13,
        ACT_SLL   = 5'd14,
        ACT_SLLV  = 5'd15,
        ACT_SLT   = 5'd16,
        ACT_SLTU  = 5'd17,
        ACT_SRA   = 5'd18,
        ACT_SRAV  = 5'd19,
        ACT_SRL   = 5'd20,
        ACT_SRLV  = 5'd21,
        ACT_SUB   = 5'd22,
        ACT_SUBU  = 5'd23,
        ACT_XOR   = 5'd24
    } action_t;

    typedef struct packed {
        logic start;
        logic is_div;
        logic is_signed;
    } md_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] lo;
    } md_rsp_t;

    typedef struct packed {
        logic [WORD_W-1:0] write_data;
        logic              write_enable;
        logic [4:0]        write_index;
        logic              branch_taken;
        logic [WORD_W-1:0] branch_target;
        logic              overflow;
    } alu_result_t;

endpackage

// ----- design/mrx_alu.sv -----
// Combinational ALU, shifter, compare and HI/LO read path.
module mrx_alu (
    input  mrx_pkg::action_t     action,
    input  logic [31:0]          rs_value,
    input  logic [31:0]          rt_value,
    input  logic [4:0]           shift_amount,
    input  logic [4:0]           dest_index,
    input  logic [31:0]          pc_value,
    input  logic [31:0]          hi_value,
    input  logic [31:0]          lo_value,
    output mrx_pkg::alu_result_t res
);
    import mrx_pkg::*;

    logic [31:0] sum;
    logic [31:0] diff;
    logic        add_ovf;
    logic        sub_ovf;
    logic [31:0] data;
    logic        we;
    logic        br;
    logic        ovf;

    assign sum     = rs_value + rt_value;
    assign diff    = rs_value - rt_value;
    assign add_ovf = (rs_value[31] == rt_value[31]) && (sum[31] != rs_value[31]);
    assign sub_ovf = (rs_value[31] != rt_value[31]) && (diff[31] != rs_value[31]);

    always_comb
    begin
        data = '0;
        we   = 1'b0;
        br   = 1'b0;
        ovf  = 1'b0;
        unique case (action)
            ACT_ADD:
            begin
                ovf = add_ovf;
                we  = !add_ovf;
                data = add_ovf ? '0 : sum;
            end
            ACT_ADDU: begin data = sum; we = 1'b1; end
            ACT_AND:  begin data = rs_value & rt_value; we = 1'b1; end
            ACT_JR:   br = 1'b1;
            ACT_JALR:
            begin
                br   = 1'b1;
                data = pc_value + LINK_OFFSET;
                we   = 1'b1;
            end
            ACT_MFHI: begin data = hi_value; we = 1'b1; end
            ACT_MFLO: begin data = lo_value; we = 1'b1; end
            ACT_OR:   begin data = rs_value | rt_value; we = 1'b1; end
            ACT_SLL:  begin data = rt_value << shift_amount; we = 1'b1; end
            ACT_SLLV: begin data = rt_value << rs_value[4:0]; we = 1'b1; end
            ACT_SLT:
            begin
                data = {31'd0, $signed(rs_value) < $signed(rt_value)};
                we   = 1'b1;
            end
            ACT_SLTU: begin data = {31'd0, rs_value < rt_value}; we = 1'b1; end
            ACT_SRA:
            begin
                data = 32'($signed(rt_value) >>> shift_amount);
                we   = 1'b1;
            end
            ACT_SRAV:
            begin
                data = 32'($signed(rt_value) >>> rs_value[4:0]);
                we   = 1'b1;
            end
            ACT_SRL:  begin data = rt_value >> shift_amount; we = 1'b1; end
            ACT_SRLV: begin data = rt_value >> rs_value[4:0]; we = 1'b1; end
            ACT_SUB:
            begin
                ovf  = sub_ovf;
                we   = !sub_ovf;
                data = sub_ovf ? '0 : diff;
            end
            ACT_SUBU: begin data = diff; we = 1'b1; end
            ACT_XOR:  begin data = rs_value ^ rt_value; we = 1'b1; end
            // multiply, divide, HI/LO writes and unused codes give no register write
            default: ;
        endcase
    end

    assign res.write_data    = data;
    assign res.write_enable  = we;
    assign res.write_index   = we ? dest_index : 5'd0;
    assign res.branch_taken  = br;
    assign res.branch_target = br ? rs_value : 32'd0;
    assign res.overflow      = ovf;

endmodule

// ----- design/mrx_muldiv.sv -----
// Iterative multiply/divide unit built around one shared 33-bit adder.
module mrx_muldiv (
    input  logic             clk,
    input  logic             rst_n,
    input  mrx_pkg::md_req_t req,
    input  logic [31:0]      rs_value,
    input  logic [31:0]      rt_value,
    output mrx_pkg::md_rsp_t rsp
);
    import mrx_pkg::*;

    typedef enum logic [6:0] {
        MD_IDLE   = 7'b0000001,
        MD_PREP_B = 7'b0000010,
        MD_PREP_A = 7'b0000100,
        MD_STEP   = 7'b0001000,
        MD_FIX_1  = 7'b0010000,
        MD_FIX_2  = 7'b0100000,
        MD_DONE   = 7'b1000000
    } md_state_t;

    md_state_t   state_reg;
    md_state_t   state_next;
    logic [4:0]  count_reg;
    logic [31:0] mcand_reg;
    logic [31:0] aux_reg;
    logic [31:0] acc_reg;
    logic [31:0] low_reg;
    logic        is_div_reg;
    logic        neg_a_reg;
    logic        neg_b_reg;

    logic [32:0] add_a;
    logic [32:0] add_b;
    logic        add_cin;
    logic [33:0] add_sum;
    logic [32:0] shifted;

    assign shifted = {acc_reg, low_reg[31]};
    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {33'd0, add_cin};

    // Operand select for the shared adder
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        unique case (state_reg)
            MD_IDLE, MD_DONE: ;
            MD_PREP_B:
            begin
                add_b   = {1'b0, ~mcand_reg};
                add_cin = 1'b1;
            end
            MD_PREP_A:
            begin
                add_b   = {1'b0, ~low_reg};
                add_cin = 1'b1;
            end
            MD_STEP:
            begin
                if (is_div_reg)
                begin
                    add_a   = shifted;
                    add_b   = ~{1'b0, mcand_reg};
                    add_cin = 1'b1;
                end
                else
                begin
                    add_a = {1'b0, acc_reg};
                    add_b = low_reg[0] ? {1'b0, mcand_reg} : 33'd0;
                end
            end
            MD_FIX_1:
            begin
                add_cin = 1'b1;
                if (is_div_reg)
                begin
                    add_b = {1'b0, ~low_reg};
                end
                else
                begin
                    add_a = {1'b0, acc_reg};
                    add_b = {1'b0, ~aux_reg};
                end
            end
            MD_FIX_2:
            begin
                add_cin = 1'b1;
                if (is_div_reg)
                begin
                    add_b = {1'b0, ~acc_reg};
                end
                else
                begin
                    add_a = {1'b0, acc_reg};
                    add_b = {1'b0, ~mcand_reg};
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MD_IDLE:   if (req.start) state_next = MD_PREP_B;
            MD_PREP_B: state_next = MD_PREP_A;
            MD_PREP_A: state_next = MD_STEP;
            MD_STEP:   if (count_reg == 5'd0) state_next = MD_FIX_1;
            MD_FIX_1:  state_next = MD_FIX_2;
            MD_FIX_2:  state_next = MD_DONE;
            MD_DONE:   state_next = MD_IDLE;
            default:   state_next = MD_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == MD_IDLE)
                count_reg <= 5'd31;
            else if (state_reg == MD_STEP)
                count_reg <= count_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    is_div_reg <= req.is_div;
                    neg_a_reg  <= req.is_signed & rs_value[31];
                    neg_b_reg  <= req.is_signed & rt_value[31];
                    mcand_reg  <= req.is_div ? rt_value : rs_value;
                    low_reg    <= req.is_div ? rs_value : rt_value;
                    aux_reg    <= rt_value;
                    acc_reg    <= '0;
                end
            end
            // take magnitudes for a signed divide
            MD_PREP_B: if (is_div_reg && neg_b_reg) mcand_reg <= add_sum[31:0];
            MD_PREP_A: if (is_div_reg && neg_a_reg) low_reg <= add_sum[31:0];
            MD_STEP:
            begin
                if (is_div_reg)
                begin
                    if (add_sum[33])
                    begin
                        acc_reg <= add_sum[31:0];
                        low_reg <= {low_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        acc_reg <= shifted[31:0];
                        low_reg <= {low_reg[30:0], 1'b0};
                    end
                end
                else
                begin
                    acc_reg <= add_sum[32:1];
                    low_reg <= {add_sum[0], low_reg[31:1]};
                end
            end
            // sign fixups: quotient/remainder signs, or signed high word correction
            MD_FIX_1:
            begin
                if (is_div_reg)
                begin
                    if (neg_a_reg ^ neg_b_reg) low_reg <= add_sum[31:0];
                end
                else if (neg_a_reg)
                begin
                    acc_reg <= add_sum[31:0];
                end
            end
            MD_FIX_2:
            begin
                if (is_div_reg ? neg_a_reg : neg_b_reg)
                    acc_reg <= add_sum[31:0];
            end
            MD_DONE: ;
            default: ;
        endcase
    end

    assign rsp.busy = (state_reg != MD_IDLE);
    assign rsp.done = (state_reg == MD_DONE);
    assign rsp.hi   = acc_reg;
    assign rsp.lo   = low_reg;

endmodule

// ----- design/mips_rtype_execute_unit.sv -----
// Top level of the MIPS R-type execute unit with HI/LO registers.
// Executes one R-type word at a time. ALU, shift, compare, jump and HI/LO move
// words go through S_EXEC and S_DONE, and in_ready returns when the result is
// loaded; mult, multu, div and divu also wait in S_WAIT for the multiply/divide
// unit, which runs 32 single-bit steps plus sign handling on one shared 33-bit
// adder. A divide by zero skips the unit and finishes like a simple word. The
// finished result sits in an output register, so the next word is accepted
// while it waits for out_ready. Overflow on add or sub raises overflow and
// suppresses the register write; unused action codes give an all-zero result.
module mips_rtype_execute_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  action,
    input  logic [31:0] rs_value,
    input  logic [31:0] rt_value,
    input  logic [4:0]  shift_amount,
    input  logic [4:0]  dest_index,
    input  logic [31:0] pc_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] write_data,
    output logic        write_enable,
    output logic [4:0]  write_index,
    output logic        branch_taken,
    output logic [31:0] branch_target,
    output logic        overflow
);
    import mrx_pkg::*;

    `include "mips_rtype_execute_unit_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WAIT = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    action_t     op_action_reg;
    logic [31:0] op_rs_reg;
    logic [31:0] op_rt_reg;
    logic [4:0]  op_sa_reg;
    logic [4:0]  op_rd_reg;
    logic [31:0] op_pc_reg;
    logic [31:0] hi_reg;
    logic [31:0] lo_reg;
    logic        out_valid_reg;
    alu_result_t out_reg;

    md_req_t     md_req;
    md_rsp_t     md_rsp;
    alu_result_t alu_res;
    logic        is_mul;
    logic        is_div;
    logic        md_start;
    logic        out_load;
    logic        in_fire;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    assign is_mul   = (op_action_reg == ACT_MULT) || (op_action_reg == ACT_MULTU);
    assign is_div   = (op_action_reg == ACT_DIV) || (op_action_reg == ACT_DIVU);
    // drop a divide by zero: HI and LO keep their values
    assign md_start = (state_reg == S_EXEC) && (is_mul || (is_div && (op_rt_reg != 32'd0)));

    assign md_req.start     = md_start;
    assign md_req.is_div    = is_div;
    assign md_req.is_signed = (op_action_reg == ACT_MULT) || (op_action_reg == ACT_DIV);

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    mrx_muldiv u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (md_req),
        .rs_value (op_rs_reg),
        .rt_value (op_rt_reg),
        .rsp      (md_rsp)
    );

    mrx_alu u_alu (
        .action       (op_action_reg),
        .rs_value     (op_rs_reg),
        .rt_value     (op_rt_reg),
        .shift_amount (op_sa_reg),
        .dest_index   (op_rd_reg),
        .pc_value     (op_pc_reg),
        .hi_value     (hi_reg),
        .lo_value     (lo_reg),
        .res          (alu_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) state_next = S_EXEC;
            S_EXEC: state_next = md_start ? S_WAIT : S_DONE;
            S_WAIT: if (md_rsp.done) state_next = S_DONE;
            S_DONE: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            hi_reg        <= '0;
            lo_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_EXEC)
            begin
                if (op_action_reg == ACT_MTHI) hi_reg <= op_rs_reg;
                if (op_action_reg == ACT_MTLO) lo_reg <= op_rs_reg;
            end
            else if ((state_reg == S_WAIT) && md_rsp.done)
            begin
                hi_reg <= md_rsp.hi;
                lo_reg <= md_rsp.lo;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_action_reg <= action_t'(action);
            op_rs_reg     <= rs_value;
            op_rt_reg     <= rt_value;
            op_sa_reg     <= shift_amount;
            op_rd_reg     <= dest_index;
            op_pc_reg     <= pc_value;
        end
        if (out_load)
            out_reg <= alu_res;
    end

    assign out_valid     = out_valid_reg;
    assign write_data    = out_reg.write_data;
    assign write_enable  = out_reg.write_enable;
    assign write_index   = out_reg.write_index;
    assign branch_taken  = out_reg.branch_taken;
    assign branch_target = out_reg.branch_target;
    assign overflow      = out_reg.overflow;

    `MRX_ASSERT_SAME(a_md_busy_in_wait, md_rsp.busy, state_reg == S_WAIT, "muldiv busy outside wait")
    `MRX_ASSERT_NEXT(a_accept_to_exec, in_fire, state_reg == S_EXEC, "accepted word not executed")
    `MRX_ASSERT_SAME(a_ovf_no_write, out_valid_reg && overflow, !write_enable, "overflow with write")
    `MRX_ASSERT_NEXT(a_hilo_hold, state_reg != S_EXEC && state_reg != S_WAIT, $stable(hi_reg) && $stable(lo_reg), "HI/LO changed while idle")

endmodule

// ----- dv/mrx_exec_monitor.sv -----
// Scoreboard for the R-type execute unit: predicts each word and checks the results.
`timescale 1ns / 100ps

module mrx_exec_monitor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [4:0]  action,
    input  logic [31:0] rs_value,
    input  logic [31:0] rt_value,
    input  logic [4:0]  shift_amount,
    input  logic [4:0]  dest_index,
    input  logic [31:0] pc_value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] write_data,
    input  logic        write_enable,
    input  logic [4:0]  write_index,
    input  logic        branch_taken,
    input  logic [31:0] branch_target,
    input  logic        overflow,
    output int          mismatches,
    output int          outstanding
);
    import mrx_pkg::*;

    localparam logic [31:0] MOST_NEG = 32'h8000_0000;
    localparam logic [31:0] MINUS_ONE = 32'hFFFF_FFFF;

    logic [31:0] hi_reg;
    logic [31:0] lo_reg;
    alu_result_t pending_q[$];

    // Compute the result of one word and update the HI/LO copy.
    function automatic alu_result_t execute_word(
        logic [4:0]  op,
        logic [31:0] a,
        logic [31:0] b,
        logic [4:0]  sa,
        logic [4:0]  rd,
        logic [31:0] pc
    );
        alu_result_t        res;
        logic               wr;
        logic [31:0]        sum;
        logic signed [63:0] sprod;
        logic [63:0]        uprod;
        res = '0;
        wr = 1'b1;
        case (op)
            ACT_ADD:
            begin
                sum = a + b;
                res.overflow = (a[31] == b[31]) && (sum[31] != a[31]);
                res.write_data = sum;
            end
            ACT_SUB:
            begin
                sum = a - b;
                res.overflow = (a[31] != b[31]) && (sum[31] != a[31]);
                res.write_data = sum;
            end
            ACT_ADDU:  res.write_data = a + b;
            ACT_SUBU:  res.write_data = a - b;
            ACT_AND:   res.write_data = a & b;
            ACT_OR:    res.write_data = a | b;
            ACT_XOR:   res.write_data = a ^ b;
            ACT_SLT:   res.write_data = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            ACT_SLTU:  res.write_data = (a < b) ? 32'd1 : 32'd0;
            ACT_SLL:   res.write_data = b << sa;
            ACT_SLLV:  res.write_data = b << a[4:0];
            ACT_SRL:   res.write_data = b >> sa;
            ACT_SRLV:  res.write_data = b >> a[4:0];
            ACT_SRA:   res.write_data = $signed(b) >>> sa;
            ACT_SRAV:  res.write_data = $signed(b) >>> a[4:0];
            ACT_MFHI:  res.write_data = hi_reg;
            ACT_MFLO:  res.write_data = lo_reg;
            ACT_JALR:
            begin
                res.branch_taken = 1'b1;
                res.branch_target = a;
                res.write_data = pc + LINK_OFFSET;
            end
            ACT_JR:
            begin
                wr = 1'b0;
                res.branch_taken = 1'b1;
                res.branch_target = a;
            end
            ACT_MTHI:
            begin
                wr = 1'b0;
                hi_reg = a;
            end
            ACT_MTLO:
            begin
                wr = 1'b0;
                lo_reg = a;
            end
            ACT_MULT:
            begin
                wr = 1'b0;
                sprod = $signed(a) * $signed(b);
                {hi_reg, lo_reg} = sprod;
            end
            ACT_MULTU:
            begin
                wr = 1'b0;
                uprod = a * b;
                {hi_reg, lo_reg} = uprod;
            end
            ACT_DIV:
            begin
                wr = 1'b0;
                // divide by zero leaves HI and LO alone
                if (b != '0)
                begin
                    if (a == MOST_NEG && b == MINUS_ONE)
                    begin
                        lo_reg = MOST_NEG;
                        hi_reg = '0;
                    end
                    else
                    begin
                        lo_reg = $signed(a) / $signed(b);
                        hi_reg = $signed(a) % $signed(b);
                    end
                end
            end
            ACT_DIVU:
            begin
                wr = 1'b0;
                if (b != '0)
                begin
                    lo_reg = a / b;
                    hi_reg = a % b;
                end
            end
            default:   wr = 1'b0;
        endcase
        // an overflow trap drops the register write
        if (res.overflow || !wr)
        begin
            wr = 1'b0;
            res.write_data = '0;
        end
        res.write_enable = wr;
        res.write_index = wr ? rd : 5'd0;
        return res;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        alu_result_t want;
        if (!rst_n)
        begin
            hi_reg = '0;
            lo_reg = '0;
            pending_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    compare_field("write_data", want.write_data, write_data);
                    compare_field("write_enable", 32'(want.write_enable), 32'(write_enable));
                    compare_field("write_index", 32'(want.write_index), 32'(write_index));
                    compare_field("branch_taken", 32'(want.branch_taken), 32'(branch_taken));
                    compare_field("branch_target", want.branch_target, branch_target);
                    compare_field("overflow", 32'(want.overflow), 32'(overflow));
                end
            end
            if (in_valid && in_ready)
                pending_q.push_back(execute_word(action, rs_value, rt_value,
                                                 shift_amount, dest_index, pc_value));
            outstanding <= pending_q.size();
        end
    end

endmodule

// ----- dv/tb_mips_rtype_execute_unit.sv -----
// Testbench top for the R-type execute unit: reset, stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps

module tb_mips_rtype_execute_unit;
    import mrx_pkg::*;

    localparam logic [4:0] ACT_SPARE_LO = 5'd25;
    localparam logic [4:0] ACT_SPARE_HI = 5'd31;
    localparam int RANDOM_WORDS = 650;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [4:0]  action;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
    logic [4:0]  shift_amount;
    logic [4:0]  dest_index;
    logic [31:0] pc_value;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] write_data;
    logic        write_enable;
    logic [4:0]  write_index;
    logic        branch_taken;
    logic [31:0] branch_target;
    logic        overflow;
    int          mismatches;
    int          outstanding;
    bit          steady;

    mips_rtype_execute_unit u_top (.*);

    mrx_exec_monitor u_monitor (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Present one word after a random gap (none while steady) and hold it until accepted.
    task automatic send_word(logic [4:0] op, logic [31:0] a, logic [31:0] b,
                             logic [4:0] sa, logic [4:0] rd, logic [31:0] pc);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= op;
        rs_value     <= a;
        rt_value     <= b;
        shift_amount <= sa;
        dest_index   <= rd;
        pc_value     <= pc;
        do @(posedge clk); while (!in_ready);
    endtask

    // Hold off the sender until every expected result has come back.
    task automatic drain;
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return $urandom_range(0, 15);
            5:       return -$urandom_range(1, 16);
            default: return $urandom();
        endcase
    endfunction

    // result side: random stall before each word, none during steady stretches
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        logic [4:0] op;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        action       <= ACT_ADD;
        rs_value     <= '0;
        rt_value     <= '0;
        shift_amount <= '0;
        dest_index   <= '0;
        pc_value     <= '0;
        steady       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // signed overflow traps and their non-trapping neighbors, then logic and compares
        send_word(ACT_ADD,  32'h7FFF_FFFF, 32'h0000_0001, 5'd0, 5'd1, $urandom());
        send_word(ACT_ADD,  32'hFFFF_FFFF, 32'h0000_0001, 5'd0, 5'd31, $urandom());
        send_word(ACT_SUB,  32'h8000_0000, 32'h0000_0001, 5'd0, 5'd2, $urandom());
        send_word(ACT_SUB,  32'h0000_0005, 32'h0000_0007, 5'd0, 5'd0, $urandom());
        send_word(ACT_ADDU, 32'h7FFF_FFFF, 32'h0000_0001, 5'd0, 5'd3, $urandom());
        send_word(ACT_SUBU, 32'h0000_0000, 32'h0000_0001, 5'd0, 5'd4, $urandom());
        send_word(ACT_AND,  32'hFFFF_FFFF, 32'hA5A5_A5A5, 5'd0, 5'd5, $urandom());
        send_word(ACT_OR,   32'h0000_0000, 32'h0000_0000, 5'd0, 5'd6, $urandom());
        send_word(ACT_XOR,  32'hFFFF_FFFF, 32'h1234_5678, 5'd0, 5'd7, $urandom());
        send_word(ACT_SLT,  32'h8000_0000, 32'h7FFF_FFFF, 5'd0, 5'd8, $urandom());
        send_word(ACT_SLTU, 32'h8000_0000, 32'h7FFF_FFFF, 5'd0, 5'd9, $urandom());
        // shifts at full distance; variable distance uses only the low five bits
        send_word(ACT_SLL,  32'h0, 32'hFFFF_FFFF, 5'd31, 5'd10, $urandom());
        send_word(ACT_SLLV, 32'hFFFF_FFE1, 32'h0000_0003, 5'd0, 5'd11, $urandom());
        send_word(ACT_SRA,  32'h0, 32'h8000_0000, 5'd31, 5'd12, $urandom());
        send_word(ACT_SRAV, 32'h0000_003F, 32'hF000_0000, 5'd0, 5'd13, $urandom());
        send_word(ACT_SRL,  32'h0, 32'hFFFF_FFFF, 5'd31, 5'd14, $urandom());
        send_word(ACT_SRLV, 32'h0000_0020, 32'hFFFF_FFFF, 5'd0, 5'd15, $urandom());
        // divide by zero must leave HI and LO as moved in
        send_word(ACT_MTHI, 32'hAAAA_AAAA, 32'h0, 5'd0, 5'd16, $urandom());
        send_word(ACT_MTLO, 32'h5555_5555, 32'h0, 5'd0, 5'd17, $urandom());
        send_word(ACT_DIV,  32'h0000_0001, 32'h0, 5'd0, 5'd18, $urandom());
        send_word(ACT_DIVU, 32'hFFFF_FFFF, 32'h0, 5'd0, 5'd18, $urandom());
        send_word(ACT_MFHI, 32'h0, 32'h0, 5'd0, 5'd19, $urandom());
        send_word(ACT_MFLO, 32'h0, 32'h0, 5'd0, 5'd20, $urandom());
        // most negative over minus one, truncating signed divide, then mult, jumps, spare
        send_word(ACT_DIV,  32'h8000_0000, 32'hFFFF_FFFF, 5'd0, 5'd21, $urandom());
        send_word(ACT_MFHI, 32'h0, 32'h0, 5'd0, 5'd22, $urandom());
        send_word(ACT_DIV,  32'hFFFF_FFF9, 32'h0000_0002, 5'd0, 5'd23, $urandom());
        send_word(ACT_MFLO, 32'h0, 32'h0, 5'd0, 5'd24, $urandom());
        send_word(ACT_MULT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 5'd25, $urandom());
        send_word(ACT_MFHI, 32'h0, 32'h0, 5'd0, 5'd26, $urandom());
        send_word(ACT_MULTU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 5'd27, $urandom());
        send_word(ACT_MFHI, 32'h0, 32'h0, 5'd0, 5'd28, $urandom());
        send_word(ACT_JR,   32'hDEAD_BEEC, 32'h0, 5'd0, 5'd29, $urandom());
        send_word(ACT_JALR, 32'h0040_0000, 32'h0, 5'd0, 5'd30, 32'hFFFF_FFFC);
        send_word(ACT_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 5'd31, 32'hFFFF_FFFF);
        drain();

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 40 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (i % 200 == 100)
                drain();
            if ($urandom_range(0, 39) == 0)
                op = 5'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
            else
                op = 5'($urandom_range(ACT_ADD, ACT_XOR));
            send_word(op, pick_operand(), pick_operand(), 5'($urandom_range(0, 31)),
                      5'($urandom_range(0, 31)), $urandom());
        end
        steady = 1'b0;
        drain();
        repeat (50) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/mrx_pkg.sv
design/mrx_alu.sv
design/mrx_muldiv.sv
design/mips_rtype_execute_unit.sv
dv/mrx_exec_monitor.sv
dv/tb_mips_rtype_execute_unit.sv
